[src/lbmc_pkg.sv]
// ----------------------------------------------------------------------------
// lbmc_pkg: lamp blink mode controller package
// Shared types, command codes and lamp mode helpers.
// ----------------------------------------------------------------------------
package lbmc_pkg;

	localparam int unsigned NUM_LAMPS_DEF = 8;
	localparam int unsigned MAX_LAMPS     = 8;
	localparam logic [7:0]  FULL_LEVEL    = 8'd255;
	localparam logic [15:0] DEF_DURATION  = 16'd500;

	typedef enum logic [3:0] {
		CMD_TICK   = 4'd0,
		CMD_ON     = 4'd1,
		CMD_OFF    = 4'd2,
		CMD_STATE  = 4'd3,
		CMD_BRIGHT = 4'd4,
		CMD_BLINK  = 4'd5,
		CMD_STOP   = 4'd6,
		CMD_MASK   = 4'd7,
		CMD_INIT   = 4'd8
	} cmd_code_t;

	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_ON    = 2'd1,
		MODE_DIM   = 2'd2,
		MODE_BLINK = 2'd3
	} mode_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic [3:0]  command;
		logic [2:0]  lamp_index;
		logic [7:0]  level;
		logic        want_on;
		logic [15:0] on_duration;
		logic [15:0] off_duration;
		logic [31:0] now_ms;
		logic [7:0]  lamp_mask;
	} cmd_beat_t;

	typedef struct packed {
		logic [7:0] output_mask;
		logic [1:0] lamp_mode;
		logic [7:0] lamp_level;
	} res_beat_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} ctrl_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  lit;
	} look_t;

	function automatic look_t apply_level(input logic [7:0] lvl);
		look_t r;
		if (lvl == FULL_LEVEL) begin
			r.mode = MODE_ON;
			r.lit  = 1'b1;
		end else if (lvl != 8'd0) begin
			r.mode = MODE_DIM;
			r.lit  = 1'b1;
		end else begin
			r.mode = MODE_OFF;
			r.lit  = 1'b0;
		end
		return r;
	endfunction

endpackage

[src/lbmc_stream_if.sv]
// ----------------------------------------------------------------------------
// lbmc_stream_if: valid/ready channel
// Carries one beat of payload per handshake.
// ----------------------------------------------------------------------------
interface lbmc_stream_if #(
	parameter type payload_t = lbmc_pkg::cmd_beat_t
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[src/lamp_blink_mode_controller_core.sv]
// ----------------------------------------------------------------------------
// lamp_blink_mode_controller_core: lamp bank mode and blink controller
// A command beat taken in the idle state is registered in the command register; the result
// register loads in the execute state, once any earlier result has been taken.
// A new command is taken while the previous result still waits to be taken.
// Reset: every lamp off, level 255, blink durations 500 ms, toggle time 0.
// ----------------------------------------------------------------------------
module lamp_blink_mode_controller_core #(
	parameter int unsigned NUM_LAMPS = lbmc_pkg::NUM_LAMPS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	lbmc_stream_if.sink   in_ch,
	lbmc_stream_if.source out_ch
);

	lbmc_pkg::ctrl_cmd_t ctrl_cmd;
	logic                in_ready;
	logic                out_valid;
	lbmc_pkg::res_beat_t res_beat;

	lbmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ch.ready),
		.cmd       (ctrl_cmd)
	);

	lbmc_datapath #(
		.NUM_LAMPS (NUM_LAMPS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (ctrl_cmd),
		.in_beat  (in_ch.payload),
		.out_beat (res_beat)
	);

	assign in_ch.ready    = in_ready;
	assign out_ch.valid   = out_valid;
	assign out_ch.payload = res_beat;

endmodule

[src/lbmc_ctrl.sv]
// ----------------------------------------------------------------------------
// lbmc_ctrl: controller
// Sequences capture and execution of one command beat, owns result valid.
// ----------------------------------------------------------------------------
module lbmc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output lbmc_pkg::ctrl_cmd_t cmd
);

	lbmc_pkg::state_t state_q;
	lbmc_pkg::state_t state_d;
	logic             out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			lbmc_pkg::ST_IDLE: begin
				if (in_valid) state_d = lbmc_pkg::ST_EXEC;
			end
			lbmc_pkg::ST_EXEC: begin
				if (!out_valid_q || out_ready) state_d = lbmc_pkg::ST_IDLE;
			end
			default: state_d = lbmc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		case (state_q)
			lbmc_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			lbmc_pkg::ST_EXEC: begin
				cmd.execute = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lbmc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.execute) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_capture_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == lbmc_pkg::ST_EXEC)
		else $error("capture not followed by execute state");

	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |=> out_valid_q && state_q == lbmc_pkg::ST_IDLE)
		else $error("execute did not present a result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |-> !out_valid_q || out_ready)
		else $error("result overwritten before taken");

endmodule

[src/lbmc_datapath.sv]
// ----------------------------------------------------------------------------
// lbmc_datapath: per-lamp state and result register
// Holds the captured command, updates all lamp lanes, forms the result.
// ----------------------------------------------------------------------------
module lbmc_datapath #(
	parameter int unsigned NUM_LAMPS = lbmc_pkg::NUM_LAMPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lbmc_pkg::ctrl_cmd_t cmd,
	input  lbmc_pkg::cmd_beat_t in_beat,
	output lbmc_pkg::res_beat_t out_beat
);

	lbmc_pkg::cmd_beat_t cmd_q;
	lbmc_pkg::res_beat_t res_q;
	lbmc_pkg::res_beat_t res_d;

	lbmc_pkg::mode_t mode_q  [NUM_LAMPS];
	lbmc_pkg::mode_t mode_d  [NUM_LAMPS];
	logic [7:0]      level_q [NUM_LAMPS];
	logic [7:0]      level_d [NUM_LAMPS];
	logic            lit_q   [NUM_LAMPS];
	logic            lit_d   [NUM_LAMPS];
	logic            phase_q [NUM_LAMPS];
	logic            phase_d [NUM_LAMPS];
	logic [15:0]     ont_q   [NUM_LAMPS];
	logic [15:0]     ont_d   [NUM_LAMPS];
	logic [15:0]     offt_q  [NUM_LAMPS];
	logic [15:0]     offt_d  [NUM_LAMPS];
	logic [31:0]     tog_q   [NUM_LAMPS];
	logic [31:0]     tog_d   [NUM_LAMPS];
	logic [31:0]     elapsed [NUM_LAMPS];
	logic [15:0]     limit   [NUM_LAMPS];
	logic            sel     [NUM_LAMPS];
	lbmc_pkg::look_t look_new[NUM_LAMPS];
	lbmc_pkg::look_t look_old[NUM_LAMPS];

	always_ff @(posedge clk) begin
		if (cmd.capture) cmd_q <= in_beat;
		if (cmd.execute) res_q <= res_d;
	end

	always_comb begin
		for (int i = 0; i < NUM_LAMPS; i++) begin
			elapsed[i]  = cmd_q.now_ms - tog_q[i];
			limit[i]    = phase_q[i] ? ont_q[i] : offt_q[i];
			sel[i]      = cmd_q.lamp_index == 3'(i);
			look_new[i] = lbmc_pkg::apply_level(cmd_q.level);
			look_old[i] = lbmc_pkg::apply_level(level_q[i]);
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_LAMPS; i++) begin
			mode_d[i]  = mode_q[i];
			level_d[i] = level_q[i];
			lit_d[i]   = lit_q[i];
			phase_d[i] = phase_q[i];
			ont_d[i]   = ont_q[i];
			offt_d[i]  = offt_q[i];
			tog_d[i]   = tog_q[i];
			case (cmd_q.command)
				lbmc_pkg::CMD_TICK: begin
					if (mode_q[i] == lbmc_pkg::MODE_BLINK && elapsed[i] >= {16'd0, limit[i]})
					begin
						phase_d[i] = ~phase_q[i];
						lit_d[i]   = ~phase_q[i];
						tog_d[i]   = cmd_q.now_ms;
					end
				end
				lbmc_pkg::CMD_ON: begin
					if (sel[i]) begin
						level_d[i] = cmd_q.level;
						mode_d[i]  = look_new[i].mode;
						lit_d[i]   = look_new[i].lit;
					end
				end
				lbmc_pkg::CMD_OFF: begin
					if (sel[i]) begin
						mode_d[i] = lbmc_pkg::MODE_OFF;
						lit_d[i]  = 1'b0;
					end
				end
				lbmc_pkg::CMD_STATE: begin
					if (sel[i]) begin
						mode_d[i] = cmd_q.want_on ? look_old[i].mode : lbmc_pkg::MODE_OFF;
						lit_d[i]  = cmd_q.want_on & look_old[i].lit;
					end
				end
				lbmc_pkg::CMD_BRIGHT: begin
					if (sel[i]) begin
						level_d[i] = cmd_q.level;
						if (mode_q[i] == lbmc_pkg::MODE_ON || mode_q[i] == lbmc_pkg::MODE_DIM)
						begin
							mode_d[i] = look_new[i].mode;
							lit_d[i]  = look_new[i].lit;
						end
					end
				end
				lbmc_pkg::CMD_BLINK: begin
					if (sel[i]) begin
						mode_d[i]  = lbmc_pkg::MODE_BLINK;
						ont_d[i]   = cmd_q.on_duration;
						offt_d[i]  = cmd_q.off_duration;
						phase_d[i] = 1'b1;
						lit_d[i]   = 1'b1;
						tog_d[i]   = 32'd0;
					end
				end
				lbmc_pkg::CMD_STOP: begin
					if (sel[i] && mode_q[i] == lbmc_pkg::MODE_BLINK) begin
						mode_d[i] = look_old[i].mode;
						lit_d[i]  = look_old[i].lit;
					end
				end
				lbmc_pkg::CMD_MASK: begin
					mode_d[i] = cmd_q.lamp_mask[i] ? look_old[i].mode : lbmc_pkg::MODE_OFF;
					lit_d[i]  = cmd_q.lamp_mask[i] & look_old[i].lit;
				end
				lbmc_pkg::CMD_INIT: begin
					mode_d[i]  = lbmc_pkg::MODE_OFF;
					level_d[i] = lbmc_pkg::FULL_LEVEL;
					lit_d[i]   = 1'b0;
					phase_d[i] = 1'b0;
					tog_d[i]   = 32'd0;
				end
				default: begin
					mode_d[i] = mode_q[i];
				end
			endcase
		end
	end

	always_comb begin
		res_d = '0;
		for (int i = 0; i < NUM_LAMPS; i++) begin
			res_d.output_mask[i] = lit_d[i];
			if (sel[i]) begin
				res_d.lamp_mode  = res_d.lamp_mode | mode_d[i];
				res_d.lamp_level = res_d.lamp_level | level_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LAMPS; i++) begin
				mode_q[i]  <= lbmc_pkg::MODE_OFF;
				level_q[i] <= lbmc_pkg::FULL_LEVEL;
				lit_q[i]   <= 1'b0;
				phase_q[i] <= 1'b0;
				ont_q[i]   <= lbmc_pkg::DEF_DURATION;
				offt_q[i]  <= lbmc_pkg::DEF_DURATION;
				tog_q[i]   <= 32'd0;
			end
		end else if (cmd.execute) begin
			for (int i = 0; i < NUM_LAMPS; i++) begin
				mode_q[i]  <= mode_d[i];
				level_q[i] <= level_d[i];
				lit_q[i]   <= lit_d[i];
				phase_q[i] <= phase_d[i];
				ont_q[i]   <= ont_d[i];
				offt_q[i]  <= offt_d[i];
				tog_q[i]   <= tog_d[i];
			end
		end
	end

	assign out_beat = res_q;

endmodule

[tb/lbmc_checker.sv]
// ----------------------------------------------------------------------------
// lbmc_checker: result checker for the lamp blink mode controller
// Watches the command and result channels, keeps its own copy of every
// lamp's mode, level, lit bit, blink phase, durations and toggle time,
// predicts the result beat of each accepted command and compares it,
// field by field, with the result beats as they are taken.
// ----------------------------------------------------------------------------
module lbmc_checker import lbmc_pkg::*; #(
	parameter int unsigned NUM_LAMPS = NUM_LAMPS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  logic      cmd_ready,
	input  cmd_beat_t cmd_beat,
	input  logic      res_valid,
	input  logic      res_ready,
	input  res_beat_t res_beat,
	output int        mismatches,
	output int        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LAMPS = (NUM_LAMPS > MAX_LAMPS) ? MAX_LAMPS : NUM_LAMPS;

	mode_t       mode_q     [MAX_LAMPS];
	logic [7:0]  level_q    [MAX_LAMPS];
	logic        lit_q      [MAX_LAMPS];
	logic        phase_q    [MAX_LAMPS];
	logic [15:0] lit_ms_q   [MAX_LAMPS];
	logic [15:0] dark_ms_q  [MAX_LAMPS];
	logic [31:0] toggled_q  [MAX_LAMPS];

	res_beat_t   expected_q [$];
	res_beat_t   due;
	int          fail_total;

	function automatic void dark_lamp(input int i);
		mode_q[i] = MODE_OFF;
		lit_q[i]  = 1'b0;
	endfunction

	function automatic void light_lamp(input int i);
		if (level_q[i] == FULL_LEVEL) begin
			mode_q[i] = MODE_ON;
			lit_q[i]  = 1'b1;
		end else if (level_q[i] != 8'd0) begin
			mode_q[i] = MODE_DIM;
			lit_q[i]  = 1'b1;
		end else begin
			dark_lamp(i);
		end
	endfunction

	function automatic res_beat_t predict_beat(input cmd_beat_t b);
		res_beat_t   r;
		int          idx;
		logic        hit;
		logic [31:0] elapsed;
		logic [15:0] span;
		idx = b.lamp_index;
		hit = (idx < LAMPS);
		case (b.command)
			CMD_TICK: begin
				for (int i = 0; i < LAMPS; i++) begin
					if (mode_q[i] == MODE_BLINK) begin
						elapsed = b.now_ms - toggled_q[i];
						span    = phase_q[i] ? lit_ms_q[i] : dark_ms_q[i];
						if (elapsed >= {16'd0, span}) begin
							phase_q[i]   = ~phase_q[i];
							lit_q[i]     = phase_q[i];
							toggled_q[i] = b.now_ms;
						end
					end
				end
			end
			CMD_ON: begin
				if (hit) begin
					level_q[idx] = b.level;
					light_lamp(idx);
				end
			end
			CMD_OFF: begin
				if (hit)
					dark_lamp(idx);
			end
			CMD_STATE: begin
				if (hit) begin
					if (b.want_on)
						light_lamp(idx);
					else
						dark_lamp(idx);
				end
			end
			CMD_BRIGHT: begin
				if (hit) begin
					level_q[idx] = b.level;
					if (mode_q[idx] == MODE_ON || mode_q[idx] == MODE_DIM)
						light_lamp(idx);
				end
			end
			CMD_BLINK: begin
				if (hit) begin
					mode_q[idx]    = MODE_BLINK;
					lit_ms_q[idx]  = b.on_duration;
					dark_ms_q[idx] = b.off_duration;
					phase_q[idx]   = 1'b1;
					lit_q[idx]     = 1'b1;
					toggled_q[idx] = 32'd0;
				end
			end
			CMD_STOP: begin
				if (hit && mode_q[idx] == MODE_BLINK)
					light_lamp(idx);
			end
			CMD_MASK: begin
				for (int i = 0; i < LAMPS; i++) begin
					if (b.lamp_mask[i])
						light_lamp(i);
					else
						dark_lamp(i);
				end
			end
			CMD_INIT: begin
				for (int i = 0; i < LAMPS; i++) begin
					mode_q[i]    = MODE_OFF;
					level_q[i]   = FULL_LEVEL;
					lit_q[i]     = 1'b0;
					phase_q[i]   = 1'b0;
					toggled_q[i] = 32'd0;
				end
			end
			default: begin
			end
		endcase
		r.output_mask = 8'd0;
		for (int i = 0; i < LAMPS; i++)
			r.output_mask[i] = lit_q[i];
		r.lamp_mode  = hit ? mode_q[idx] : MODE_OFF;
		r.lamp_level = hit ? level_q[idx] : 8'd0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LAMPS; i++) begin
				mode_q[i]    = MODE_OFF;
				level_q[i]   = FULL_LEVEL;
				lit_q[i]     = 1'b0;
				phase_q[i]   = 1'b0;
				lit_ms_q[i]  = DEF_DURATION;
				dark_ms_q[i] = DEF_DURATION;
				toggled_q[i] = 32'd0;
			end
			expected_q.delete();
			fail_total = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (expected_q.size() == 0) begin
					$error("result beat with no command outstanding: %0h", res_beat);
					fail_total++;
				end else begin
					due = expected_q.pop_front();
					if (res_beat.output_mask !== due.output_mask) begin
						$error("output_mask: expected %0h, got %0h",
							due.output_mask, res_beat.output_mask);
						fail_total++;
					end
					if (res_beat.lamp_mode !== due.lamp_mode) begin
						$error("lamp_mode: expected %0d, got %0d",
							due.lamp_mode, res_beat.lamp_mode);
						fail_total++;
					end
					if (res_beat.lamp_level !== due.lamp_level) begin
						$error("lamp_level: expected %0d, got %0d",
							due.lamp_level, res_beat.lamp_level);
						fail_total++;
					end
				end
			end
			if (cmd_valid && cmd_ready)
				expected_q.push_back(predict_beat(cmd_beat));
			mismatches  <= fail_total;
			outstanding <= expected_q.size();
		end
	end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for lamp_blink_mode_controller_core
// Drives command beats with random gaps and result back-pressure: a short
// directed pass over every command and the blink timing corners, then
// blink bursts with advancing tick times mixed with random commands.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lbmc_pkg::*;

	localparam int unsigned LAMP_COUNT   = NUM_LAMPS_DEF;
	localparam int          ITEM_TARGET  = 850;
	localparam int          GAP_MAX      = 13;
	localparam int          CMD_CODE_TOP = 15;
	localparam int          DRAIN_CYCLES = 20;
	localparam int          LIMIT_NS     = 3_000_000;

	logic        clk;
	logic        arst_n;
	bit          calm;
	int          issued;
	int          mismatches;
	int          outstanding;
	logic [31:0] ms_now;

	lbmc_stream_if #(.payload_t(cmd_beat_t)) cmd_ch ();
	lbmc_stream_if #(.payload_t(res_beat_t)) res_ch ();

	lamp_blink_mode_controller_core #(
		.NUM_LAMPS(LAMP_COUNT)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (cmd_ch),
		.out_ch (res_ch)
	);

	lbmc_checker #(
		.NUM_LAMPS(LAMP_COUNT)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_ch.valid),
		.cmd_ready   (cmd_ch.ready),
		.cmd_beat    (cmd_ch.payload),
		.res_valid   (res_ch.valid),
		.res_ready   (res_ch.ready),
		.res_beat    (res_ch.payload),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("tb_top failed");
		$finish;
	end

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, GAP_MAX);
	endfunction

	function automatic logic [3:0] pick_command();
		int r;
		r = $urandom_range(0, 19);
		if (r == 19)
			return 4'($urandom_range(int'(CMD_INIT) + 1, CMD_CODE_TOP));
		else if (r == 18)
			return CMD_INIT;
		else
			return 4'($urandom_range(int'(CMD_TICK), int'(CMD_MASK)));
	endfunction

	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 5))
			0:       return 8'd0;
			1:       return FULL_LEVEL;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_span();
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom);
		else
			return 16'($urandom_range(0, 40));
	endfunction

	function automatic cmd_beat_t random_beat();
		cmd_beat_t b;
		b.command      = pick_command();
		b.lamp_index   = 3'($urandom);
		b.level        = pick_level();
		b.want_on      = 1'($urandom);
		b.on_duration  = pick_span();
		b.off_duration = pick_span();
		b.now_ms       = $urandom;
		b.lamp_mask    = 8'($urandom);
		return b;
	endfunction

	task automatic send_beat(input cmd_beat_t b);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.payload <= b;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		issued++;
	endtask

	task automatic send_cmd(input logic [3:0] code, input logic [2:0] lamp,
			input logic [7:0] lvl, input logic want, input logic [15:0] on_d,
			input logic [15:0] off_d, input logic [31:0] now, input logic [7:0] mask);
		cmd_beat_t b;
		b.command      = code;
		b.lamp_index   = lamp;
		b.level        = lvl;
		b.want_on      = want;
		b.on_duration  = on_d;
		b.off_duration = off_d;
		b.now_ms       = now;
		b.lamp_mask    = mask;
		send_beat(b);
	endtask

	initial begin : rx_side
		int gap;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
		end
	end

	initial begin : stimulus
		cmd_beat_t b;
		arst_n         <= 1'b0;
		cmd_ch.valid   <= 1'b0;
		cmd_ch.payload <= '0;
		calm   = 1'b0;
		issued = 0;
		ms_now = 32'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// levels: full, dimmed, zero
		send_cmd(CMD_ON,     3'd0, 8'd255, 1'b0, 16'd0, 16'd0, 32'd0, 8'h00);
		send_cmd(CMD_ON,     3'd1, 8'd128, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
		send_cmd(CMD_ON,     3'd2, 8'd0,   1'b0, 16'd0, 16'd0, 32'd0, 8'h00);
		send_cmd(CMD_ON,     3'd7, 8'd1,   1'b0, 16'd0, 16'd0, 32'd0, 8'h00);
		// brightness while lit and while dark
		send_cmd(CMD_BRIGHT, 3'd1, 8'd255, 1'b0, 16'd0, 16'd0, 32'd0, 8'h00);
		send_cmd(CMD_BRIGHT, 3'd2, 8'd77,  1'b0, 16'd0, 16'd0, 32'd0, 8'h00);
		send_cmd(CMD_BRIGHT, 3'd0, 8'd0,   1'b0, 16'd0, 16'd0, 32'd0, 8'h00);
		send_cmd(CMD_STATE,  3'd2, 8'h5A,  1'b1, 16'd0, 16'd0, 32'd0, 8'h00);
		send_cmd(CMD_STATE,  3'd0, 8'hA5,  1'b1, 16'd0, 16'd0, 32'd0, 8'h00);
		send_cmd(CMD_STATE,  3'd1, 8'hFF,  1'b0, 16'd0, 16'd0, 32'd0, 8'h00);
		// blink: zero, full and short durations
		send_cmd(CMD_BLINK,  3'd3, 8'd0,   1'b0, 16'd0, 16'd0, 32'd0, 8'h00);
		send_cmd(CMD_BLINK,  3'd4, 8'd0,   1'b0, 16'hFFFF, 16'hFFFF, 32'd0, 8'h00);
		send_cmd(CMD_BLINK,  3'd5, 8'd0,   1'b0, 16'd10, 16'd20, 32'd0, 8'h00);
		send_cmd(CMD_TICK,   3'd5, 8'd0,   1'b0, 16'd0, 16'd0, 32'd5, 8'h00);
		send_cmd(CMD_TICK,   3'd5, 8'd0,   1'b0, 16'd0, 16'd0, 32'd10, 8'h00);
		send_cmd(CMD_TICK,   3'd5, 8'd0,   1'b0, 16'd0, 16'd0, 32'd30, 8'h00);
		send_cmd(CMD_TICK,   3'd4, 8'd0,   1'b0, 16'd0, 16'd0, 32'd65535, 8'h00);
		// millisecond count at its top value, just before the wrap
		send_cmd(CMD_TICK,   3'd4, 8'd0,   1'b0, 16'd0, 16'd0, 32'hFFFF_FFFF, 8'h00);
		send_cmd(CMD_STOP,   3'd4, 8'd0,   1'b0, 16'd0, 16'd0, 32'd0, 8'h00);
		send_cmd(CMD_BRIGHT, 3'd5, 8'd50,  1'b0, 16'd0, 16'd0, 32'd0, 8'h00);
		send_cmd(CMD_STOP,   3'd5, 8'd0,   1'b0, 16'd0, 16'd0, 32'd0, 8'h00);
		send_cmd(CMD_MASK,   3'd0, 8'd0,   1'b0, 16'd0, 16'd0, 32'd0, 8'hA5);
		send_cmd(CMD_OFF,    3'd6, 8'd0,   1'b0, 16'd0, 16'd0, 32'd0, 8'hFF);
		send_cmd(4'(CMD_CODE_TOP), 3'd3, 8'd0, 1'b1, 16'd0, 16'd0, 32'd0, 8'hFF);
		send_cmd(CMD_INIT,   3'd7, 8'd0,   1'b0, 16'd0, 16'd0, 32'd0, 8'h00);

		while (issued < ITEM_TARGET) begin
			calm = ($urandom_range(0, 5) == 0);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					b = random_beat();
					b.command = CMD_BLINK;
					if ($urandom_range(0, 1) != 0)
						ms_now = $urandom_range(0, 20);
					send_beat(b);
					repeat ($urandom_range(3, 12)) begin
						b = random_beat();
						if ($urandom_range(0, 3) != 0) begin
							ms_now += $urandom_range(0, 40);
							b.command = CMD_TICK;
							b.now_ms  = ms_now;
						end
						send_beat(b);
					end
				end
				6, 7, 8: begin
					repeat ($urandom_range(1, 6))
						send_beat(random_beat());
				end
				default: begin
					// jump towards the wrap point or anywhere
					if ($urandom_range(0, 1) != 0)
						ms_now = 32'hFFFF_FFE0 + $urandom_range(0, 31);
					else
						ms_now = $urandom;
					b = random_beat();
					b.command = CMD_TICK;
					b.now_ms  = ms_now;
					send_beat(b);
				end
			endcase
		end
		cmd_ch.valid <= 1'b0;

		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
